>>> rtl/bsp_pkg.sv
// ----------------------------------------------------------------------------
// bsp_pkg
// shared types, codes and the microcode table of the byte string predicate
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int MAX_LEN_DEF = 256;
  localparam int BYTE_W      = 8;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 8;
  localparam int STEP_W      = 3;

  typedef enum logic [1:0] {
    REQ_LEFT  = 2'd0,
    REQ_RIGHT = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    OP_EQ       = 3'd0,
    OP_NE       = 3'd1,
    OP_LT       = 3'd2,
    OP_GT       = 3'd3,
    OP_CONTAINS = 3'd4,
    OP_PREFIX   = 3'd5,
    OP_SUFFIX   = 3'd6,
    OP_UNSUP    = 3'd7
  } oper_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OPCODE   = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2
  } ord_t;

  // datapath actions
  typedef enum logic [2:0] {
    A_NOP     = 3'd0,
    A_INIT    = 3'd1,
    A_CMP     = 3'd2,
    A_NEXTPOS = 3'd3,
    A_FINISH  = 3'd4
  } act_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEVER    = 3'd0,
    C_ALWAYS   = 3'd1,
    C_EARLY    = 3'd2,
    C_IDX_DONE = 3'd3,
    C_BYTE_GO  = 3'd4,
    C_RETRY    = 3'd5
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
  } uword_t;

  // status from the datapath that the jump conditions test
  typedef struct packed {
    logic early;
    logic idx_done;
    logic byte_go;
    logic retry;
  } flags_t;

  localparam step_t ST_INIT   = 3'd0;
  localparam step_t ST_LOOP   = 3'd1;
  localparam step_t ST_CMP    = 3'd2;
  localparam step_t ST_WEND   = 3'd3;
  localparam step_t ST_FINISH = 3'd4;
  localparam step_t ST_NEXT   = 3'd5;

  // one control word per step
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    case (step)
      ST_INIT:   w = '{act: A_INIT,    cond: C_EARLY,    target: ST_FINISH};
      ST_LOOP:   w = '{act: A_NOP,     cond: C_IDX_DONE, target: ST_WEND};
      ST_CMP:    w = '{act: A_CMP,     cond: C_BYTE_GO,  target: ST_LOOP};
      ST_WEND:   w = '{act: A_NOP,     cond: C_RETRY,    target: ST_NEXT};
      ST_FINISH: w = '{act: A_FINISH,  cond: C_ALWAYS,   target: ST_INIT};
      ST_NEXT:   w = '{act: A_NEXTPOS, cond: C_ALWAYS,   target: ST_LOOP};
      default:   w = '{act: A_NOP,     cond: C_ALWAYS,   target: ST_INIT};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/bsp_ram.sv
// ----------------------------------------------------------------------------
// bsp_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module bsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bsp_seq.sv
// ----------------------------------------------------------------------------
// bsp_seq
// step counter over the microcode table with conditional jumps
// ----------------------------------------------------------------------------
module bsp_seq
  import bsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   run,
  input  logic   hold,
  input  flags_t flags,
  output act_t   act
);

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   taken;

  assign uw  = ucode_rom(pc);
  assign act = run ? uw.act : A_NOP;

  always_comb begin
    case (uw.cond)
      C_ALWAYS:   taken = 1'b1;
      C_EARLY:    taken = flags.early;
      C_IDX_DONE: taken = flags.idx_done;
      C_BYTE_GO:  taken = flags.byte_go;
      C_RETRY:    taken = flags.retry;
      default:    taken = 1'b0;
    endcase
  end

  always_comb begin
    if (!run) begin
      pc_next = ST_INIT;
    end else if (hold) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = uw.target;
    end else begin
      pc_next = pc + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_INIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> rtl/byte_string_predicate.sv
// ----------------------------------------------------------------------------
// byte_string_predicate
// compare or search two byte strings loaded one byte per word
// ----------------------------------------------------------------------------
//  channel   dir  payload                                    handshake
//  s_axis    in   tuser: req_type; tdata: data_byte,         tvalid/tready
//                 operator_code, text_mode
//  m_axis    out  tdata: match, error                        tvalid/tready
//
//  load words are taken while idle, also when the operand is full.
//  an evaluate runs the microcode: a setup step, then per compared byte a
//  memory read step and a compare step; a window ends after a mismatch or
//  after its last byte, a contains window restarts at the next offset,
//  and a last step posts the result.
//  s_axis_tready is low from an evaluate until its result is in the output
//  register; that step waits while a previous result is not yet taken.
//  rst is synchronous; operand memories need no clearing after reset.
module byte_string_predicate
  import bsp_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // data_byte, operator_code, text_mode
  input  logic [1:0]           s_axis_tuser,  // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata   // match, error
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

  logic              busy;
  logic [CW-1:0]     left_count;
  logic [CW-1:0]     right_count;
  logic              overflowed;
  oper_t             op;
  logic              text;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     off;
  logic [CW-1:0]     n;
  ord_t              ord;
  logic              match;
  err_t              error;

  logic              acc;
  req_t              req;
  logic [BYTE_W-1:0] in_byte;
  logic              left_we;
  logic              right_we;
  logic [BYTE_W-1:0] ldata;
  logic [BYTE_W-1:0] rdata;
  logic [CW-1:0]     rpos;
  logic [CW:0]       win_end;
  logic              l_eq;
  logic              l_lt;
  logic              l_gt;
  logic              match_calc;
  logic              hold;
  act_t              act;
  flags_t            flags;

  assign s_axis_tready = !busy;
  assign acc      = s_axis_tvalid && s_axis_tready;
  assign req      = req_t'(s_axis_tuser);
  assign in_byte  = s_axis_tdata[7:0];
  assign left_we  = acc && (req == REQ_LEFT) && (left_count < FULL);
  assign right_we = acc && (req == REQ_RIGHT) && (right_count < FULL);
  assign rpos     = off + idx;

  bsp_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_left (
    .clk   (clk),
    .we    (left_we),
    .waddr (left_count[AW-1:0]),
    .wdata (in_byte),
    .raddr (idx[AW-1:0]),
    .rdata (ldata)
  );

  bsp_ram #(.WIDTH(BYTE_W), .DEPTH(MAX_LEN)) u_right (
    .clk   (clk),
    .we    (right_we),
    .waddr (right_count[AW-1:0]),
    .wdata (in_byte),
    .raddr (rpos[AW-1:0]),
    .rdata (rdata)
  );

  assign l_eq = (left_count == right_count);
  assign l_lt = (left_count < right_count);
  assign l_gt = (left_count > right_count);
  assign win_end = {1'b0, off} + {1'b0, left_count};

  // status for the jump conditions
  always_comb begin
    flags.early = overflowed || (op == OP_UNSUP)
               || ((op inside {OP_EQ, OP_NE}) && !l_eq)
               || ((op inside {OP_CONTAINS, OP_PREFIX, OP_SUFFIX}) && l_gt);
    flags.idx_done = (idx == n);
    flags.byte_go  = (ldata == rdata) && !(text && (ldata == '0));
    flags.retry    = (op == OP_CONTAINS) && (ord != ORD_EQ)
                  && (win_end < {1'b0, right_count});
  end

  always_comb begin
    case (op)
      OP_EQ:       match_calc = l_eq && (ord == ORD_EQ);
      OP_NE:       match_calc = !(l_eq && (ord == ORD_EQ));
      OP_LT:       match_calc = (ord == ORD_LT) || ((ord == ORD_EQ) && l_lt);
      OP_GT:       match_calc = (ord == ORD_GT) || ((ord == ORD_EQ) && l_gt);
      OP_CONTAINS,
      OP_PREFIX,
      OP_SUFFIX:   match_calc = !l_gt && (ord == ORD_EQ);
      default:     match_calc = 1'b0;
    endcase
  end

  assign hold = (act == A_FINISH) && m_axis_tvalid && !m_axis_tready;

  bsp_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .run   (busy),
    .hold  (hold),
    .flags (flags),
    .act   (act)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      left_count    <= '0;
      right_count   <= '0;
      overflowed    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (acc) begin
        case (req)
          REQ_LEFT: begin
            if (left_count < FULL) begin
              left_count <= left_count + CW'(1);
            end else begin
              overflowed <= 1'b1;
            end
          end
          REQ_RIGHT: begin
            if (right_count < FULL) begin
              right_count <= right_count + CW'(1);
            end else begin
              overflowed <= 1'b1;
            end
          end
          REQ_EVAL: busy <= 1'b1;
          default: ;
        endcase
      end
      if (act == A_FINISH && !hold) begin
        busy          <= 1'b0;
        left_count    <= '0;
        right_count   <= '0;
        overflowed    <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (acc && req == REQ_EVAL) begin
      op   <= oper_t'(s_axis_tdata[10:8]);
      text <= s_axis_tdata[11];
    end
    case (act)
      A_INIT: begin
        idx <= '0;
        ord <= ORD_EQ;
        off <= (op == OP_SUFFIX) ? (right_count - left_count) : '0;
        n   <= ((op == OP_LT || op == OP_GT) && l_gt) ? right_count : left_count;
      end
      A_CMP: begin
        idx <= idx + CW'(1);
        if (ldata != rdata) begin
          ord <= (ldata < rdata) ? ORD_LT : ORD_GT;
        end
      end
      A_NEXTPOS: begin
        off <= off + CW'(1);
        idx <= '0;
        ord <= ORD_EQ;
      end
      A_FINISH: begin
        if (!hold) begin
          if (overflowed) begin
            error <= ERR_OVERFLOW;
            match <= 1'b0;
          end else if (op == OP_UNSUP) begin
            error <= ERR_OPCODE;
            match <= 1'b0;
          end else begin
            error <= ERR_NONE;
            match <= match_calc;
          end
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tdata = {5'b0, error, match};

endmodule

>>> rtl/bsp_checker.sv
// ----------------------------------------------------------------------------
// bsp_checker
// port level checks of the byte string predicate, bound to the top level
// ----------------------------------------------------------------------------
module bsp_checker
  import bsp_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [S_TDATA_W-1:0] s_axis_tdata,
  input logic [1:0]           s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // an evaluate word closes the input until its result is posted
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc && (s_axis_tuser == REQ_EVAL) |=> !s_axis_tready)
    else $error("input open right after evaluate");

  // load words never stall the input
  a_load_open: assert property (@(posedge clk) disable iff (rst)
    in_acc && ((s_axis_tuser == REQ_LEFT) || (s_axis_tuser == REQ_RIGHT))
    |=> s_axis_tready)
    else $error("input closed after a load word");

  // a match never comes with an error
  a_match_err: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && (m_axis_tdata[2:1] != ERR_NONE)))
    else $error("match set together with error");

endmodule

bind byte_string_predicate bsp_checker u_bsp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/tb_byte_string_predicate.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_string_predicate
// self-checking bench for the byte string compare and substring search block
// ----------------------------------------------------------------------------
// operand bytes and evaluate requests are queued by an initial block and sent
// by a clocked driver; every accepted input word updates a local copy of the
// operand buffers, and each evaluate predicts one verdict that the monitor
// compares with the next result word. directed words cover empty operands,
// all operators, text versus byte compares, overflow and a full subject
// buffer; random words follow, mostly related pattern/subject pairs.
// ----------------------------------------------------------------------------
module tb_byte_string_predicate;
  import bsp_pkg::*;

  localparam int MAX_LEN        = MAX_LEN_DEF;
  localparam int RANDOM_WORDS   = 80;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 100;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    req_t       req;
    logic [7:0] data;
    oper_t      op;
    logic       text;
  } word_t;

  typedef struct {
    logic match;
    err_t err;
  } verdict_t;

  typedef logic [7:0] byte_q_t [$];

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // data_byte, operator_code, text_mode
  logic [1:0]           s_axis_tuser = '0;  // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // match, error

  word_t    pending_words [$];
  verdict_t expected_verdicts [$];

  // local copy of the operand buffers
  logic [7:0] left_mem  [MAX_LEN];
  logic [7:0] right_mem [MAX_LEN];
  int         left_len  = 0;
  int         right_len = 0;
  bit         ovf       = 1'b0;

  int total_words  = 0;
  int in_accepted  = 0;
  int err_count    = 0;
  int evals_seen   = 0;
  int matches_seen = 0;
  int errors_seen  = 0;
  int idle_cycles  = 0;
  int hold_cnt     = 0;
  bit hold_done    = 1'b0;
  int big_left     = 0;

  byte_string_predicate #(.MAX_LEN(MAX_LEN)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // sign of left[0..n) against right[off..off+n)
  function automatic int order_at(int off, int n, bit text_cmp);
    for (int i = 0; i < n; i++) begin
      if (left_mem[i] != right_mem[off + i]) return (left_mem[i] < right_mem[off + i]) ? -1 : 1;
      if (text_cmp && left_mem[i] == 8'h00) return 0;
    end
    return 0;
  endfunction

  function automatic bit predicate_hit(oper_t op, bit text_cmp);
    int l1;
    int l2;
    int n;
    int r;
    l1 = left_len;
    l2 = right_len;
    case (op)
      OP_EQ: return (l1 == l2) && (order_at(0, l1, text_cmp) == 0);
      OP_NE: return (l1 != l2) || (order_at(0, l1, text_cmp) != 0);
      OP_LT, OP_GT: begin
        n = (l1 < l2) ? l1 : l2;
        r = order_at(0, n, text_cmp);
        if (r < 0 || (r == 0 && l1 < l2)) return op == OP_LT;
        if (r > 0 || (r == 0 && l1 > l2)) return op == OP_GT;
        return 1'b0;
      end
      OP_CONTAINS: begin
        if (l1 > l2) return 1'b0;
        if (l1 == 0) return 1'b1;
        for (int p = 0; p + l1 <= l2; p++) begin
          if (order_at(p, l1, text_cmp) == 0) return 1'b1;
        end
        return 1'b0;
      end
      OP_PREFIX: return (l1 <= l2) && (order_at(0, l1, text_cmp) == 0);
      OP_SUFFIX: return (l1 <= l2) && (order_at(l2 - l1, l1, text_cmp) == 0);
      default: return 1'b0;
    endcase
  endfunction

  task automatic predict_verdict(input word_t w);
    verdict_t v;
    case (w.req)
      REQ_LEFT: begin
        if (left_len < MAX_LEN) begin
          left_mem[left_len] = w.data;
          left_len++;
        end else begin
          ovf = 1'b1;
        end
      end
      REQ_RIGHT: begin
        if (right_len < MAX_LEN) begin
          right_mem[right_len] = w.data;
          right_len++;
        end else begin
          ovf = 1'b1;
        end
      end
      REQ_EVAL: begin
        v.match = 1'b0;
        v.err   = ERR_NONE;
        if (ovf) v.err = ERR_OVERFLOW;
        else if (w.op == OP_UNSUP) v.err = ERR_OPCODE;
        else v.match = predicate_hit(w.op, w.text);
        expected_verdicts.push_back(v);
        left_len  = 0;
        right_len = 0;
        ovf       = 1'b0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_word(input req_t r, input logic [7:0] d, input oper_t o, input logic t);
    word_t w;
    w.req  = r;
    w.data = d;
    w.op   = o;
    w.text = t;
    pending_words.push_back(w);
  endtask

  // unused fields carry random noise
  task automatic push_load(input req_t side, input logic [7:0] d);
    push_word(side, d, oper_t'(3'($urandom)), 1'($urandom));
  endtask

  task automatic push_eval(input oper_t o, input logic t);
    push_word(REQ_EVAL, 8'($urandom), o, t);
  endtask

  task automatic push_operands(input byte_q_t pat, input byte_q_t subj);
    int li;
    int ri;
    li = 0;
    ri = 0;
    while (li < pat.size() || ri < subj.size()) begin
      if (ri >= subj.size() || (li < pat.size() && $urandom_range(1) == 1)) begin
        push_load(REQ_LEFT, pat[li]);
        li++;
      end else begin
        push_load(REQ_RIGHT, subj[ri]);
        ri++;
      end
      if ($urandom_range(39) == 0) push_word(REQ_NONE, 8'($urandom), oper_t'(3'($urandom)),
                                             1'($urandom));
    end
  endtask

  function automatic logic [7:0] pick_byte(int alpha);
    case (alpha)
      0: return 8'($urandom);
      1: return 8'h61 + 8'($urandom_range(1));
      default: return ($urandom_range(3) == 0) ? 8'h00 : 8'h61 + 8'($urandom_range(1));
    endcase
  endfunction

  task automatic push_random_case();
    byte_q_t subj;
    byte_q_t pat;
    int      ls;
    int      lp;
    int      st;
    int      alpha;
    int      kind;
    bit      big;
    oper_t   op;
    big = 1'b0;
    if (big_left > 0 && $urandom_range(29) == 0) begin
      big = 1'b1;
      big_left--;
    end
    ls    = big ? $urandom_range(256, 64) : $urandom_range(12);
    alpha = $urandom_range(2);
    kind  = $urandom_range(6);
    for (int i = 0; i < ls; i++) subj.push_back(pick_byte(alpha));
    case (kind)
      0: begin
        lp = big ? $urandom_range(32) : $urandom_range(12);
        for (int i = 0; i < lp; i++) pat.push_back(pick_byte(alpha));
      end
      1: begin
        if (ls > 0) begin
          st = $urandom_range(ls - 1);
          lp = $urandom_range(ls - st);
          for (int i = 0; i < lp; i++) pat.push_back(subj[st + i]);
        end
      end
      2: begin
        lp = $urandom_range(ls);
        for (int i = 0; i < lp; i++) pat.push_back(subj[i]);
      end
      3: begin
        lp = $urandom_range(ls);
        for (int i = ls - lp; i < ls; i++) pat.push_back(subj[i]);
      end
      4: pat = subj;
      5: begin
        pat = subj;
        if (ls > 0) pat[$urandom_range(ls - 1)] = pick_byte(alpha);
      end
      default: begin
        // pattern one byte longer than the subject, unless the subject is full
        pat = subj;
        if (ls < MAX_LEN) pat.push_back(pick_byte(alpha));
      end
    endcase
    push_operands(pat, subj);
    op = ($urandom_range(15) == 0) ? OP_UNSUP : oper_t'(3'($urandom_range(6)));
    push_eval(op, 1'($urandom));
    if ($urandom_range(9) == 0) push_word(REQ_NONE, 8'($urandom), oper_t'(3'($urandom)),
                                          1'($urandom));
  endtask

  initial begin
    byte_q_t a;
    byte_q_t b;
    int      start;

    // empty operands under every operator
    for (int o = 0; o < 8; o++) push_eval(oper_t'(o), 1'b0);
    push_eval(OP_EQ, 1'b1);
    push_word(REQ_NONE, 8'hff, OP_UNSUP, 1'b1);
    push_eval(OP_NE, 1'b1);

    // equal strings are neither smaller nor greater
    a = '{8'h61, 8'h62, 8'h63};
    push_operands(a, a);
    push_eval(OP_LT, 1'b0);
    push_operands(a, a);
    push_eval(OP_GT, 1'b1);
    // shorter prefix is smaller
    b = '{8'h61, 8'h62};
    push_operands(b, a);
    push_eval(OP_LT, 1'b0);
    push_operands(b, a);
    push_eval(OP_PREFIX, 1'b0);
    b = '{8'h62, 8'h63};
    push_operands(b, a);
    push_eval(OP_SUFFIX, 1'b1);
    b = '{8'h63, 8'h61};
    push_operands(b, a);
    push_eval(OP_CONTAINS, 1'b0);

    // shared zero byte ends a text compare, not a byte compare
    a = '{8'h61, 8'h62, 8'h00, 8'h78};
    b = '{8'h61, 8'h62, 8'h00, 8'h79};
    push_operands(a, b);
    push_eval(OP_EQ, 1'b1);
    push_operands(a, b);
    push_eval(OP_EQ, 1'b0);

    // unsigned extremes
    a = '{8'hff};
    b = '{8'h00};
    push_operands(a, b);
    push_eval(OP_GT, 1'b0);
    push_operands(b, a);
    push_eval(OP_LT, 1'b1);

    // overflow on the left wins over a bad operator, buffers are empty after
    for (int i = 0; i < MAX_LEN + 1; i++) push_load(REQ_LEFT, 8'($urandom));
    push_eval(OP_UNSUP, 1'b0);
    push_eval(OP_EQ, 1'b0);

    // full subject buffer without overflow, pattern at its very end
    a.delete();
    for (int i = 0; i < MAX_LEN; i++) a.push_back(8'($urandom));
    b.delete();
    for (int i = MAX_LEN - 8; i < MAX_LEN; i++) b.push_back(a[i]);
    push_operands(b, a);
    push_eval(OP_CONTAINS, 1'b0);

    start = pending_words.size();
    while (pending_words.size() - start < RANDOM_WORDS) push_random_case();
    total_words = pending_words.size();

    @(posedge clk);
    while (rst) @(posedge clk);
    while (pending_words.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d input words and %0d evaluates (%0d matches, %0d errors)",
             in_accepted, evals_seen, matches_seen, errors_seen);
    $display("operators, text and byte compares, overflow and a full subject under stalls");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driving

  // first phase: sender idles rarely, receiver often; second swaps; third none
  function automatic int idle_pct(bit sender);
    if (in_accepted * 3 < total_words) return sender ? 14 : 82;
    if (in_accepted * 3 < total_words * 2) return sender ? 82 : 14;
    return 0;
  endfunction

  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
        w = pending_words.pop_front();
        s_axis_tdata  <= {4'b0, w.text, w.op, w.data};
        s_axis_tuser  <= w.req;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // one long hold-off at the start of the third phase lets results back up
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && total_words > 0 && in_accepted * 3 >= total_words * 2) begin
      hold_done     <= 1'b1;
      hold_cnt      <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    word_t    w;
    verdict_t v;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        w.data = s_axis_tdata[7:0];
        w.op   = oper_t'(s_axis_tdata[10:8]);
        w.text = s_axis_tdata[11];
        w.req  = req_t'(s_axis_tuser);
        predict_verdict(w);
        in_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        evals_seen++;
        if (m_axis_tdata[0]) matches_seen++;
        if (m_axis_tdata[2:1] != ERR_NONE) errors_seen++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result word 0x%02h with none expected", m_axis_tdata));
        end else begin
          v = expected_verdicts.pop_front();
          if (m_axis_tdata[0] !== v.match)
            report_mismatch($sformatf("match %0b, expected %0b", m_axis_tdata[0], v.match));
          if (m_axis_tdata[2:1] !== v.err)
            report_mismatch($sformatf("error %0d, expected %0d", m_axis_tdata[2:1], v.err));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
